// File: design/dbwc_pkg.sv
package dbwc_pkg;

   localparam int WinW = 32;
   localparam logic [31:0] WinMax = 32'hFFFF_FFFF;

   localparam logic [15:0] DeltaReset = 16'd13107;
   localparam logic [19:0] MinRttWinReset = 20'd10000;
   localparam logic [31:0] MinWindowReset = 32'd262144;
   localparam logic [31:0] WindowReset = 32'd65536;

   typedef enum logic [1:0] {
      CSR_DELTA = 2'd0,
      CSR_MIN_RTT_WINDOW = 2'd1,
      CSR_MIN_WINDOW = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRTT,
      ST_MIN,
      ST_MUL_P,
      ST_MUL_D,
      ST_DIV_DEC,
      ST_DIV_STEP,
      ST_WIN,
      ST_VEL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } unit_cmd_type;

   function automatic logic [15:0] round_window(input logic [31:0] w);
      logic [16:0] r;
      r = 17'(({1'b0, w} + 33'h8000) >> 16);
      return r[16] ? 16'hFFFF : r[15:0];
   endfunction

endpackage

// File: design/dbwc_serial_unit.sv
// Bit-serial multiply (shift-add, one multiplier bit a cycle) and
// restoring divide (one quotient bit a cycle) on a 128-bit accumulator:
// 64-bit partial remainder high, quotient or product low.
module dbwc_serial_unit (
   input  logic clock,
   input  logic reset,
   input  dbwc_pkg::unit_cmd_type cmd,
   input  logic [63:0] opa,
   input  logic [63:0] opb,
   output logic busy,
   output logic [63:0] result
);
   import dbwc_pkg::*;

   logic [6:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic is_div_ff, is_div_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0] b_ff, b_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [64:0] rem_sh;
   logic [65:0] diff;
   logic [127:0] addend;
   logic [128:0] sum;

   always_comb begin
      count_in = count_ff;
      busy_in = busy_ff;
      is_div_in = is_div_ff;
      acc_in = acc_ff;
      b_in = b_ff;
      mcand_in = mcand_ff;
      rem_sh = acc_ff[127:63];
      diff = {1'b0, rem_sh} - {2'b00, b_ff};
      addend = {64'd0, mcand_ff, 32'd0};
      sum = {1'b0, acc_ff} + (acc_ff[0] ? {1'b0, addend} : 129'd0);
      if (cmd.start) begin
         busy_in = 1'b1;
         is_div_in = cmd.is_div;
         if (cmd.is_div) begin
            // dividend opa (64 bits) sits in the low half
            acc_in = {64'd0, opa};
            b_in = opb;
            count_in = 7'd64;
         end else begin
            // multiplier opb[31:0] low, multiplicand opa[31:0]
            acc_in = {96'd0, opb[31:0]};
            mcand_in = opa[31:0];
            b_in = opb;
            count_in = 7'd32;
         end
      end else if (busy_ff) begin
         if (is_div_ff) begin
            if (!diff[65]) acc_in = {diff[63:0], acc_ff[62:0], 1'b1};
            else acc_in = {acc_ff[126:0], 1'b0};
         end else begin
            acc_in = sum[128:1];
         end
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
      is_div_ff <= is_div_in;
      acc_ff <= acc_in;
      b_ff <= b_in;
      mcand_ff <= mcand_in;
   end

   assign busy = busy_ff;
   assign result = acc_ff[63:0];
endmodule

// File: design/delay_based_window_controller.sv
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser: operation; tdata: send_time_ms, ack_time_ms
// rsp     | out | rsp_tvalid/tready    | tdata: window_packets, in_slow_start_out, smoothed_rtt_out
// csr     | in  | csr_write            | index, data (32 bits)
// A send request goes from idle straight to the output state. An ack with both divides
// passes set-up states (smoothed RTT, minimum, multiply start), a 32-step serial multiply
// (window x delta), a 64-step divide for the queue test, a 64-step divide for the step
// size, then window, velocity and output states. Zero queue delay skips the test divide;
// a zero window x delta skips the step divide.
// Synchronous active-high reset; the controller starts idle in slow start.
// One request at a time; a response held in the output register does not stop
// the next request being taken, only the next response being loaded.
module delay_based_window_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // send_time_ms[31:0], ack_time_ms[63:32]
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // window_packets[15:0], in_slow_start_out[16],
                                   // smoothed_rtt_out[48:17], zero fill
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import dbwc_pkg::*;

   // configuration
   logic [15:0] delta_ff;
   logic [19:0] min_rtt_win_ff;
   logic [31:0] min_window_ff;

   // controller state
   logic [31:0] window_ff, window_in;
   logic [15:0] latched_ff, latched_in;
   logic [31:0] srtt_ff, srtt_in;
   logic        srtt_valid_ff, srtt_valid_in;
   logic [31:0] low_rtt_ff, low_rtt_in;
   logic [31:0] low_time_ff, low_time_in;
   logic [15:0] vel_ff, vel_in;
   logic        up_ff, up_in;
   logic [7:0]  upcnt_ff, upcnt_in;
   logic        ss_ff, ss_in;

   // working registers
   state_type   state_ff, state_in;
   logic [31:0] snd_ff, snd_in, ack_ff, ack_in;
   logic        op_ff, op_in;
   logic [31:0] q_ff, q_in;
   logic [63:0] p_ff, p_in;
   logic        inc_ff, inc_in;
   logic [31:0] step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [48:0] rsp_ff, rsp_in;

   unit_cmd_type cmd;
   logic [63:0]  opa, opb;
   logic         busy;
   logic [63:0]  ures;

   dbwc_serial_unit u_unit (
      .clock(clock), .reset(reset), .cmd(cmd), .opa(opa), .opb(opb),
      .busy(busy), .result(ures)
   );

   logic [31:0] latest, sample_q8, min_q8;
   logic [34:0] smooth;
   logic [32:0] lim;
   logic [32:0] wnext;
   logic [31:0] wsel;
   logic [15:0] rw;
   logic        gup;
   logic [7:0]  ucnt;

   always_comb begin
      state_in = state_ff;
      window_in = window_ff; latched_in = latched_ff; srtt_in = srtt_ff;
      srtt_valid_in = srtt_valid_ff; low_rtt_in = low_rtt_ff;
      low_time_in = low_time_ff; vel_in = vel_ff; up_in = up_ff;
      upcnt_in = upcnt_ff; ss_in = ss_ff;
      snd_in = snd_ff; ack_in = ack_ff; op_in = op_ff;
      q_in = q_ff; p_in = p_ff; inc_in = inc_ff; step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in = rsp_ff;
      cmd = '0; opa = '0; opb = '0;
      req_tready = 1'b0;

      latest = ack_ff - snd_ff;
      sample_q8 = (latest[31:24] != 8'd0) ? WinMax : {latest[23:0], 8'd0};
      smooth = 35'({srtt_ff, 3'b000} - {3'b000, srtt_ff}) + 35'(sample_q8) + 35'd4;
      lim = {1'b0, low_time_ff} + {13'd0, min_rtt_win_ff};
      min_q8 = (low_rtt_ff[31:24] != 8'd0) ? WinMax : {low_rtt_ff[23:0], 8'd0};
      wnext = '0; wsel = '0; rw = '0; gup = 1'b0; ucnt = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && req_tready) begin
               snd_in = req_tdata[31:0];
               ack_in = req_tdata[63:32];
               op_in = req_tuser;
               state_in = req_tuser ? ST_SRTT : ST_OUT;
            end
         end
         ST_SRTT: begin
            srtt_in = srtt_valid_ff ? smooth[34:3] : sample_q8;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            // first ack still sees the valid flag clear here
            if (!srtt_valid_ff || latest < low_rtt_ff) begin
               low_rtt_in = latest; low_time_in = ack_ff;
            end else if ({1'b0, ack_ff} >= lim) begin
               low_rtt_in = latest; low_time_in = ack_ff;
            end
            srtt_valid_in = 1'b1;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            q_in = (srtt_ff > min_q8) ? srtt_ff - min_q8 : 32'd0;
            cmd.start = 1'b1;
            opa = {32'd0, window_ff};
            opb = {48'd0, delta_ff};
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            if (!busy) begin
               p_in = ures;
               if (q_ff == 32'd0) begin
                  inc_in = 1'b1;
                  state_in = ST_DIV_STEP;
                  if (ures != 64'd0) begin
                     cmd.start = 1'b1; cmd.is_div = 1'b1;
                     opa = {vel_ff, 48'd0}; opb = ures;
                  end
               end else begin
                  cmd.start = 1'b1; cmd.is_div = 1'b1;
                  opa = {srtt_ff, 32'd0}; opb = {32'd0, q_ff};
                  state_in = ST_DIV_DEC;
               end
            end
         end
         ST_DIV_DEC: begin
            if (!busy) begin
               inc_in = p_ff <= ures;
               state_in = ST_DIV_STEP;
               if (p_ff != 64'd0) begin
                  cmd.start = 1'b1; cmd.is_div = 1'b1;
                  opa = {vel_ff, 48'd0}; opb = p_ff;
               end
            end
         end
         ST_DIV_STEP: begin
            if (!busy) begin
               if (p_ff == 64'd0 || ures[63:32] != 32'd0) step_in = WinMax;
               else step_in = ures[31:0];
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            if (inc_ff) begin
               wnext = ss_ff ? {window_ff, 1'b0}
                             : {1'b0, window_ff} + {1'b0, step_ff};
               wsel = wnext[32] ? WinMax : wnext[31:0];
            end else begin
               ss_in = 1'b0;
               wsel = (window_ff > step_ff) ? window_ff - step_ff : 32'd0;
            end
            window_in = (wsel < min_window_ff) ? min_window_ff : wsel;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            rw = round_window(window_ff);
            gup = rw > latched_ff;
            ucnt = gup ? ((upcnt_ff == 8'hFF) ? upcnt_ff : upcnt_ff + 8'd1) : 8'd0;
            up_in = gup; upcnt_in = ucnt;
            if (gup && up_ff && ucnt >= 8'd3)
               vel_in = vel_ff[15] ? 16'hFFFF : {vel_ff[14:0], 1'b0};
            else if (!gup)
               vel_in = 16'd1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // send: latch window; both: present response
            if (!op_ff) latched_in = round_window(window_ff);
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_in = {srtt_ff, ss_ff, round_window(window_ff)};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         delta_ff <= DeltaReset;
         min_rtt_win_ff <= MinRttWinReset;
         min_window_ff <= MinWindowReset;
         window_ff <= WindowReset;
         latched_ff <= '0; srtt_ff <= '0; srtt_valid_ff <= 1'b0;
         low_rtt_ff <= '0; low_time_ff <= '0; vel_ff <= 16'd1;
         up_ff <= 1'b1; upcnt_ff <= '0; ss_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         window_ff <= window_in; latched_ff <= latched_in; srtt_ff <= srtt_in;
         srtt_valid_ff <= srtt_valid_in; low_rtt_ff <= low_rtt_in;
         low_time_ff <= low_time_in; vel_ff <= vel_in; up_ff <= up_in;
         upcnt_ff <= upcnt_in; ss_ff <= ss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_DELTA: delta_ff <= csr_data[15:0];
               CSR_MIN_RTT_WINDOW: min_rtt_win_ff <= csr_data[19:0];
               CSR_MIN_WINDOW: min_window_ff <= csr_data;
               default: ;
            endcase
         end
      end
      snd_ff <= snd_in; ack_ff <= ack_in; op_ff <= op_in;
      q_ff <= q_in; p_ff <= p_in; inc_ff <= inc_in; step_ff <= step_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_ff};
endmodule

// File: test/delay_based_window_controller_tb.sv
`timescale 1ns / 1ps

module delay_based_window_controller_tb;
   import dbwc_pkg::*;

   // one response as it leaves the block
   typedef struct packed {
      logic [31:0] srtt;
      logic        slow;
      logic [15:0] win;
   } window_report_type;

   // Copa-style window arithmetic mirrored at the block's widths
   class window_scoreboard;
      logic [15:0] delta;
      logic [19:0] rtt_age;
      logic [31:0] win_floor;
      logic [31:0] win;
      logic [15:0] latched;
      logic [31:0] srtt;
      bit          srtt_ok;
      logic [31:0] low_rtt;
      logic [31:0] low_time;
      logic [15:0] vel;
      bit          rising;
      logic [7:0]  ups;
      bit          slow;
      window_report_type pending[$];
      int          errors;

      function new();
         delta = DeltaReset; rtt_age = MinRttWinReset; win_floor = MinWindowReset;
         win = WindowReset; latched = 0; srtt = 0; srtt_ok = 0; low_rtt = 0;
         low_time = 0; vel = 1; rising = 1; ups = 0; slow = 1; errors = 0;
      endfunction

      function logic [15:0] rounded();
         logic [32:0] r;
         r = ({1'b0, win} + 33'h8000) >> 16;
         return (r > 33'd65535) ? 16'hFFFF : r[15:0];
      endfunction

      function logic [31:0] clip(logic [63:0] x);
         return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_DELTA: delta = v[15:0];
            CSR_MIN_RTT_WINDOW: rtt_age = v[19:0];
            CSR_MIN_WINDOW: win_floor = v;
            default: ;
         endcase
      endfunction

      function void note_request(bit is_ack, logic [31:0] snd, logic [31:0] ack);
         logic [31:0] rtt, samp, minq, q, step;
         logic [63:0] p, w;
         logic [15:0] rw;
         logic [16:0] dv;
         bit inc, was_up, first;
         if (!is_ack) begin
            latched = rounded();
         end else begin
            rtt = ack - snd;
            samp = clip({32'd0, rtt} << 8);
            first = !srtt_ok;
            if (first) begin
               srtt = samp; srtt_ok = 1;
            end else begin
               srtt = 32'((64'd7 * srtt + samp + 64'd4) >> 3);
            end
            if (first || rtt < low_rtt || {32'd0, ack} >= {32'd0, low_time} + rtt_age) begin
               low_rtt = rtt; low_time = ack;
            end
            minq = clip({32'd0, low_rtt} << 8);
            q = (srtt > minq) ? srtt - minq : 0;
            p = {32'd0, win} * delta;
            inc = (q == 0) ? 1 : (p <= (({32'd0, srtt} << 32) / q));
            step = (p == 0) ? 32'hFFFF_FFFF : clip(({48'd0, vel} << 48) / p);
            w = {32'd0, win};
            if (inc) begin
               w = slow ? w * 2 : w + step;
               w = clip(w);
            end else begin
               slow = 0;
               w = (w > step) ? w - step : 0;
            end
            if (w < win_floor) w = win_floor;
            win = w[31:0];
            was_up = rising;
            rw = rounded();
            if (rw > latched) begin
               rising = 1;
               if (ups != 8'hFF) ups++;
            end else begin
               rising = 0; ups = 0;
            end
            if (rising && was_up && ups >= 3) begin
               dv = {vel, 1'b0};
               vel = dv[16] ? 16'hFFFF : dv[15:0];
            end else if (!rising) begin
               vel = 1;
            end
         end
         pending.push_back('{srtt: srtt, slow: slow, win: rounded()});
      endfunction

      function void check_response(logic [55:0] d);
         window_report_type want, got;
         got = d[48:0];
         if (pending.size() == 0) begin
            $error("response with nothing expected: %h", d);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.win !== want.win) begin
            $error("window_packets expected %0d got %0d", want.win, got.win); errors++;
         end
         if (got.slow !== want.slow) begin
            $error("in_slow_start_out expected %0d got %0d", want.slow, got.slow); errors++;
         end
         if (got.srtt !== want.srtt) begin
            $error("smoothed_rtt_out expected %h got %h", want.srtt, got.srtt); errors++;
         end
         if (d[55:49] !== 7'd0) begin
            $error("rsp_tdata fill expected 0 got %h", d[55:49]); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = 0;   // send_time_ms[31:0], ack_time_ms[63:32]
   logic        req_tuser = 0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;       // window_packets, in_slow_start_out, smoothed_rtt_out
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   window_scoreboard board;
   bit          calm = 0;        // no idling in the closing stretch
   int unsigned cycles = 0;
   logic [31:0] clock_ms = 0;    // running sender clock for well-formed acks

   localparam int unsigned CycleLimit = 2_000_000;

   delay_based_window_controller dut (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: sample at the rising edge, change tready at the falling edge
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);

   initial begin : sink
      int gap;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   // drive one request; returns at a falling edge after acceptance with
   // tvalid still high, so the next request can follow without a gap
   task automatic send_request(bit is_ack, logic [31:0] snd, logic [31:0] ack);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= is_ack;
      req_tdata <= {ack, snd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(is_ack, snd, ack);
      @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(negedge clock);
      csr_write <= 0;
      board.set_reg(idx, v);
      @(negedge clock);
   endtask

   // let the block drain before touching its registers
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // a well-formed exchange: a send, then an ack with a plausible RTT
   task automatic flow_pair(int unsigned max_rtt);
      logic [31:0] snd;
      clock_ms += $urandom_range(0, 50);
      snd = clock_ms;
      send_request(0, $urandom, $urandom);
      send_request(1, snd, snd + $urandom_range(1, max_rtt));
   endtask

   initial begin : stimulus
      int n;
      board = new();
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: both events, first ack, field extremes, wrap and saturation
      send_request(0, 0, 0);
      send_request(1, 32'd100, 32'd140);          // first ack seeds srtt and minimum
      send_request(1, 32'd200, 32'd260);
      send_request(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(1, 32'hFFFF_FFF0, 32'd16);     // sample wraps past zero
      send_request(1, 32'd0, 32'hFFFF_FFFF);      // saturating Q24.8 sample
      send_request(1, 32'd0, 32'd0);              // zero RTT
      send_request(1, 32'd5, 32'd5);
      send_request(1, 32'd1, 32'd0);              // negative wraps to huge
      for (int i = 0; i < 8; i++) flow_pair(30);  // growth and velocity ramp
      drain();

      // extreme settings
      write_reg(CSR_DELTA, 32'd1);
      write_reg(CSR_MIN_RTT_WINDOW, 32'd1);
      write_reg(CSR_MIN_WINDOW, 32'd0);
      for (int i = 0; i < 6; i++) flow_pair(500);
      drain();
      write_reg(CSR_DELTA, 32'd65535);
      write_reg(CSR_MIN_RTT_WINDOW, 32'hF_FFFF);
      write_reg(CSR_MIN_WINDOW, 32'hFFFF_FFFF); // window pinned at the top
      for (int i = 0; i < 4; i++) flow_pair(100);
      drain();

      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_DELTA, (ph == 0) ? 32'd13107 : $urandom_range(1, 65535));
         write_reg(CSR_MIN_RTT_WINDOW, $urandom_range(1, (ph % 2) ? 1000000 : 200));
         write_reg(CSR_MIN_WINDOW, (ph % 3 == 0) ? 32'd262144 : $urandom_range(0, 32'h0010_0000));
         if (ph == 5) calm = 1;
         for (int i = 0; i < 93; i++) begin
            n = $urandom_range(0, 9);
            if (n < 8) flow_pair((n < 4) ? 20 : 400);
            else send_request(n[0], $urandom, $urandom);  // noise
         end
         drain();
      end

      drain();
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// File: delay_based_window_controller.f
design/dbwc_pkg.sv
design/dbwc_serial_unit.sv
design/delay_based_window_controller.sv
test/delay_based_window_controller_tb.sv
